@@ hdl/huffman_tree_decoder_core_assert.svh @@
// assertion helpers shared by the decoder modules
// both expect clk_i and rst_ni in scope
`ifndef HUFFMAN_TREE_DECODER_CORE_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define HTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/htd_pkg.sv @@
`default_nettype none

package htd_pkg;

  // operation codes of a request
  localparam logic [1:0] OP_NODE  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CODE  = 2'd2;

  localparam int unsigned NODE_W    = 9;
  localparam int unsigned ENTRY_W   = 2 * NODE_W;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned TOTAL_W   = 24;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);

  localparam logic [NODE_W-1:0] LEAF_MAX = 9'd255;

  localparam int unsigned TREE_NODES_DEF  = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 24;

  typedef struct packed {
    logic              start;
    logic              word;
    logic [NODE_W-1:0] root_node;
    logic [31:0]       code_word;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             final_res;
    logic             error;
  } push_t;

endpackage

`default_nettype wire

@@ hdl/htd_if.sv @@
`default_nettype none

interface htd_req_if;
  import htd_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [SLOT_W-1:0]   node_slot;
  logic [NODE_W-1:0]   child_zero;
  logic [NODE_W-1:0]   child_one;
  logic [NODE_W-1:0]   root_node;
  logic [TOTAL_W-1:0]  total_bytes;
  logic [31:0]         code_word;

  modport source (
    output valid, operation, node_slot, child_zero, child_one, root_node,
           total_bytes, code_word,
    input  ready
  );
  modport sink (
    input  valid, operation, node_slot, child_zero, child_one, root_node,
           total_bytes, code_word,
    output ready
  );
endinterface

interface htd_res_if;
  import htd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;
  logic             final_res;
  logic             error;

  modport source (
    output valid, symbol, last, final_res, error,
    input  ready
  );
  modport sink (
    input  valid, symbol, last, final_res, error,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/huffman_tree_decoder_core.sv @@
// channel  dir  modport  payload
// req_i    in   sink     operation node_slot child_zero child_one root_node
//                        total_bytes code_word
// res_o    out  source   symbol last final_res error
//
// a code word first fetches the current node, then walks one code bit per cycle
// unless a full result register stalls it, until the final byte or bit 31,
// and then hands over the last byte.
// the rate is set by the node table read that each tree step waits on.
// a full result register that is not taken stalls the walk at the next leaf.
// rst_ni clears control state at once; node table contents are unknown until written.
`default_nettype none

module huffman_tree_decoder_core #(
  parameter int unsigned TREE_NODES  = htd_pkg::TREE_NODES_DEF,
  parameter int unsigned COUNT_WIDTH = htd_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  htd_req_if.sink    req_i,
  htd_res_if.source  res_o
);
  import htd_pkg::*;

  `include "huffman_tree_decoder_core_assert.svh"

  localparam int unsigned AddrW = $clog2(TREE_NODES);

  logic              accept;
  logic              out_free;
  logic              walker_idle;
  logic              err_push;
  logic              node_we;
  logic              rd_en;
  logic [NODE_W-1:0] rd_node;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] entry;
  logic              oor_q;
  cmd_t              cmd;
  push_t             push;

  logic             out_vld_q, out_vld_d;
  logic [SYM_W-1:0] out_sym_q;
  logic             out_last_q;
  logic             out_fin_q;
  logic             out_err_q;

  assign out_free    = !out_vld_q || res_o.ready;
  assign req_i.ready = walker_idle && out_free;
  assign accept      = req_i.valid && req_i.ready;

  assign cmd.start     = accept && (req_i.operation == OP_START);
  assign cmd.word      = accept && (req_i.operation == OP_CODE);
  assign cmd.root_node = req_i.root_node;
  assign cmd.code_word = req_i.code_word;

  assign err_push = cmd.start && (req_i.root_node <= LEAF_MAX);
  assign node_we  = accept && (req_i.operation == OP_NODE)
                    && ({1'b0, req_i.node_slot} < 9'(TREE_NODES));

  htd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TREE_NODES)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (req_i.node_slot[AddrW-1:0]),
    .wdata_i ({req_i.child_one, req_i.child_zero}),
    .re_i    (rd_en),
    .raddr_i (rd_node[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  // nodes past the table, or leaf numbers, read as an all-zero entry
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      oor_q <= !rd_node[NODE_W-1] || ({1'b0, rd_node[SLOT_W-1:0]} >= 9'(TREE_NODES));
    end
  end

  assign entry = oor_q ? '0 : rd_data;

  htd_walker #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .count_i    (COUNT_WIDTH'(req_i.total_bytes)),
    .entry_i    (entry),
    .out_free_i (out_free),
    .idle_o     (walker_idle),
    .rd_en_o    (rd_en),
    .rd_node_o  (rd_node),
    .push_o     (push)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (push.valid || err_push) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_sym_q  <= push.symbol;
      out_last_q <= push.last;
      out_fin_q  <= push.final_res;
      out_err_q  <= push.error;
    end else if (err_push) begin
      out_sym_q  <= '0;
      out_last_q <= 1'b1;
      out_fin_q  <= 1'b0;
      out_err_q  <= 1'b1;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.symbol    = out_sym_q;
  assign res_o.last      = out_last_q;
  assign res_o.final_res = out_fin_q;
  assign res_o.error     = out_err_q;

  `HTD_ASSERT_IMP(a_push_has_room, push.valid, out_free,
                  "result pushed into a full register")
  `HTD_ASSERT_IMP(a_ready_only_idle, req_i.ready, walker_idle,
                  "request taken while walking")
  `HTD_ASSERT_IMP(a_err_result_clean, out_vld_q && out_err_q,
                  out_sym_q == '0 && out_last_q && !out_fin_q,
                  "error result carries decoded data")

endmodule

`default_nettype wire

@@ hdl/htd_ram.sv @@
`default_nettype none

module htd_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/htd_walker.sv @@
`default_nettype none

module htd_walker #(
  parameter int unsigned COUNT_WIDTH = htd_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire htd_pkg::cmd_t                cmd_i,
  input  wire logic [COUNT_WIDTH-1:0]       count_i,
  input  wire logic [htd_pkg::ENTRY_W-1:0]  entry_i,
  input  wire logic                         out_free_i,
  output logic                              idle_o,
  output logic                              rd_en_o,
  output logic      [htd_pkg::NODE_W-1:0]   rd_node_o,
  output htd_pkg::push_t                    push_o
);
  import htd_pkg::*;

  `include "huffman_tree_decoder_core_assert.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(WORD_BITS - 1);

  logic [1:0]             state_q, state_d;
  logic [NODE_W-1:0]      root_q, root_d;
  logic [NODE_W-1:0]      node_q, node_d;
  logic [COUNT_WIDTH-1:0] left_q, left_d;
  logic                   active_q, active_d;
  logic                   pend_vld_q, pend_vld_d;
  logic [31:0]            word_q, word_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [SYM_W-1:0]       pend_sym_q, pend_sym_d;
  logic                   pend_fin_q, pend_fin_d;

  logic [NODE_W-1:0] child;
  logic [NODE_W-1:0] next_node;
  logic              leaf;
  logic              is_final;
  logic              stall;
  logic              step;
  logic              flush_go;

  // one tree step per cycle unless stalled: pick the child, test for a leaf, count down
  assign child     = word_q[0] ? entry_i[ENTRY_W-1:NODE_W] : entry_i[NODE_W-1:0];
  assign leaf      = (child <= LEAF_MAX);
  assign next_node = leaf ? root_q : child;
  assign is_final  = (left_q == COUNT_WIDTH'(1));
  // a new leaf needs the held one shipped first
  assign stall     = (state_q == ST_WALK) && leaf && pend_vld_q && !out_free_i;
  assign step      = (state_q == ST_WALK) && !stall;
  assign flush_go  = (state_q == ST_FLUSH) && (!pend_vld_q || out_free_i);

  assign idle_o    = (state_q == ST_IDLE);
  assign rd_en_o   = (cmd_i.word && active_q && (state_q == ST_IDLE)) || step;
  assign rd_node_o = step ? next_node : node_q;

  always_comb begin
    push_o           = '0;
    push_o.symbol    = pend_sym_q;
    push_o.final_res = pend_fin_q;
    if (step && leaf && pend_vld_q) begin
      push_o.valid = 1'b1;
    end else if (flush_go && pend_vld_q) begin
      push_o.valid = 1'b1;
      push_o.last  = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    root_d     = root_q;
    node_d     = node_q;
    left_d     = left_q;
    active_d   = active_q;
    pend_vld_d = pend_vld_q;
    word_d     = word_q;
    bit_d      = bit_q;
    pend_sym_d = pend_sym_q;
    pend_fin_d = pend_fin_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.start) begin
          root_d   = cmd_i.root_node;
          node_d   = cmd_i.root_node;
          left_d   = count_i;
          active_d = (cmd_i.root_node > LEAF_MAX) && (count_i != '0);
        end else if (cmd_i.word && active_q) begin
          word_d  = cmd_i.code_word;
          bit_d   = '0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (step) begin
          word_d = word_q >> 1;
          bit_d  = bit_q + BIT_W'(1);
          node_d = next_node;
          if (leaf) begin
            left_d     = left_q - COUNT_WIDTH'(1);
            pend_vld_d = 1'b1;
            pend_sym_d = child[SYM_W-1:0];
            pend_fin_d = is_final;
            if (is_final) begin
              active_d = 1'b0;
            end
          end
          if ((leaf && is_final) || (bit_q == LAST_BIT)) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      root_q     <= '0;
      node_q     <= '0;
      left_q     <= '0;
      active_q   <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      root_q     <= root_d;
      node_q     <= node_d;
      left_q     <= left_d;
      active_q   <= active_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    bit_q      <= bit_d;
    pend_sym_q <= pend_sym_d;
    pend_fin_q <= pend_fin_d;
  end

  `HTD_ASSERT_IMP(a_final_is_last, push_o.valid && push_o.final_res, push_o.last,
                  "final byte not marked last")
  `HTD_ASSERT_IMP(a_no_push_idle, state_q == ST_IDLE, !push_o.valid,
                  "result pushed while idle")
  `HTD_ASSERT_NXT(a_flush_ends, flush_go, state_q == ST_IDLE,
                  "flush did not return to idle")
  `HTD_ASSERT_NXT(a_final_stops, step && leaf && is_final, !active_q && state_q == ST_FLUSH,
                  "stream still active after final byte")

endmodule

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htd_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int unsigned TREE_NODES = TREE_NODES_DEF;
  localparam int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 455;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int N_ROWS = 24;

  typedef struct packed {
    logic [1:0]         operation;
    logic [SLOT_W-1:0]  node_slot;
    logic [NODE_W-1:0]  child_zero;
    logic [NODE_W-1:0]  child_one;
    logic [NODE_W-1:0]  root_node;
    logic [TOTAL_W-1:0] total_bytes;
    logic [31:0]        code_word;
  } request_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             final_res;
    logic             error;
  } result_t;

  // typed rows carry their own expectation: none, or the leaf root error
  typedef struct packed {
    request_t rq;
    bit       typed;
    bit       typed_err;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;

  htd_req_if req_if ();
  htd_res_if res_if ();

  huffman_tree_decoder_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // decoder state as the testbench sees it
  logic [ENTRY_W-1:0]     tbl_entry [TREE_NODES];
  logic [NODE_W-1:0]      walk_root;
  logic [NODE_W-1:0]      walk_node;
  logic [COUNT_WIDTH-1:0] bytes_to_go;
  bit                     stream_on;
  result_t                pending_bytes [$];

  bit       hold_typed;
  bit       hold_err;
  request_t seen_req;
  result_t  seen_res;
  int       mismatches;
  int       cycles;
  int       src_burst;
  int       sink_burst;
  int       random_items;

  // slots written so far: every child of a written node is a leaf or written
  bit       slot_used [256];
  bit [7:0] used_slots [$];

  stim_row_t directed_rows [N_ROWS] = '{
    '{'{OP_CODE,  8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'hFFFF_FFFF}, 1'b1, 1'b0},
    '{'{OP_SPARE, 8'd255, 9'd511, 9'd511, 9'd511, 24'hFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 1'b0},
    '{'{OP_START, 8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'd0},         1'b1, 1'b1},
    '{'{OP_START, 8'd0,   9'd0,   9'd0,   9'd255, 24'hFF_FFFF, 32'd0},         1'b1, 1'b1},
    '{'{OP_NODE,  8'd255, 9'd0,   9'd255, 9'd0,   24'd0,       32'd0},         1'b1, 1'b0},
    '{'{OP_NODE,  8'd1,   9'd170, 9'd511, 9'd0,   24'd0,       32'd0},         1'b1, 1'b0},
    '{'{OP_NODE,  8'd0,   9'd257, 9'd85,  9'd0,   24'd0,       32'd0},         1'b1, 1'b0},
    '{'{OP_START, 8'd0,   9'd0,   9'd0,   9'd511, 24'd0,       32'd0},         1'b1, 1'b0},
    '{'{OP_CODE,  8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'hFFFF_FFFF}, 1'b1, 1'b0},
    '{'{OP_START, 8'd0,   9'd0,   9'd0,   9'd256, 24'd5,       32'd0},         1'b1, 1'b0},
    '{'{OP_CODE,  8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'hFFFF_FFFF}, 1'b0, 1'b0},
    '{'{OP_START, 8'd0,   9'd0,   9'd0,   9'd256, 24'hFF_FFFF, 32'd0},         1'b1, 1'b0},
    '{'{OP_CODE,  8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'h0000_0000}, 1'b0, 1'b0},
    '{'{OP_CODE,  8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'h7FFF_FFFF}, 1'b0, 1'b0},
    '{'{OP_CODE,  8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'h0000_0001}, 1'b0, 1'b0},
    '{'{OP_NODE,  8'd0,   9'd511, 9'd257, 9'd0,   24'd0,       32'd0},         1'b1, 1'b0},
    '{'{OP_CODE,  8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'h3C5A_96E1}, 1'b0, 1'b0},
    '{'{OP_START, 8'd0,   9'd0,   9'd0,   9'd257, 24'd3,       32'd0},         1'b1, 1'b0},
    '{'{OP_CODE,  8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'hAAAA_AAAA}, 1'b0, 1'b0},
    '{'{OP_START, 8'd0,   9'd0,   9'd0,   9'd511, 24'hFF_FFFF, 32'd0},         1'b1, 1'b0},
    '{'{OP_CODE,  8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'hFFFF_FFFF}, 1'b0, 1'b0},
    '{'{OP_CODE,  8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'h0000_0000}, 1'b0, 1'b0},
    '{'{OP_START, 8'd0,   9'd0,   9'd0,   9'd511, 24'd1,       32'd0},         1'b1, 1'b0},
    '{'{OP_CODE,  8'd0,   9'd0,   9'd0,   9'd0,   24'd0,       32'h0000_0002}, 1'b0, 1'b0}
  };

  function automatic logic [ENTRY_W-1:0] node_entry(logic [NODE_W-1:0] node);
    if (!node[NODE_W-1] || node[SLOT_W-1:0] >= TREE_NODES) return '0;
    return tbl_entry[node[SLOT_W-1:0]];
  endfunction

  // advances the decoder state by one request and, when keep is set, queues the results it yields
  function automatic void walk_tree(request_t rq, bit keep);
    logic [ENTRY_W-1:0] entry;
    logic [NODE_W-1:0]  child;
    int                 n;
    n = 0;
    case (rq.operation)
      OP_NODE: begin
        if (rq.node_slot < TREE_NODES) tbl_entry[rq.node_slot] = {rq.child_one, rq.child_zero};
      end
      OP_START: begin
        walk_root   = rq.root_node;
        walk_node   = rq.root_node;
        bytes_to_go = rq.total_bytes;
        stream_on   = 1'b0;
        if (rq.root_node <= LEAF_MAX) begin
          if (keep) pending_bytes.push_back('{symbol: '0, last: 1'b1, final_res: 1'b0, error: 1'b1});
        end else if (bytes_to_go != '0) begin
          stream_on = 1'b1;
        end
      end
      OP_CODE: begin
        for (int b = 0; b < WORD_BITS && stream_on; b++) begin
          entry = node_entry(walk_node);
          child = rq.code_word[b] ? entry[ENTRY_W-1:NODE_W] : entry[NODE_W-1:0];
          if (child <= LEAF_MAX) begin
            bytes_to_go = bytes_to_go - 1'b1;
            walk_node   = walk_root;
            if (bytes_to_go == '0) stream_on = 1'b0;
            if (keep) pending_bytes.push_back('{symbol: child[SYM_W-1:0], last: 1'b0,
                                                final_res: !stream_on, error: 1'b0});
            n++;
          end else begin
            walk_node = child;
          end
        end
        if (keep && n > 0) pending_bytes[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [SYM_W-1:0] expv,
                                      logic [SYM_W-1:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        seen_req.operation   = req_if.operation;
        seen_req.node_slot   = req_if.node_slot;
        seen_req.child_zero  = req_if.child_zero;
        seen_req.child_one   = req_if.child_one;
        seen_req.root_node   = req_if.root_node;
        seen_req.total_bytes = req_if.total_bytes;
        seen_req.code_word   = req_if.code_word;
        walk_tree(seen_req, !hold_typed);
        if (hold_typed && hold_err)
          pending_bytes.push_back('{symbol: '0, last: 1'b1, final_res: 1'b0, error: 1'b1});
      end
      if (res_if.valid && res_if.ready) begin
        if (pending_bytes.size() == 0) begin
          $error("result with nothing expected: symbol %0d error %0d",
                 res_if.symbol, res_if.error);
          mismatches++;
        end else begin
          seen_res = pending_bytes.pop_front();
          check_field("symbol", seen_res.symbol, res_if.symbol);
          check_field("last", SYM_W'(seen_res.last), SYM_W'(res_if.last));
          check_field("final_res", SYM_W'(seen_res.final_res), SYM_W'(res_if.final_res));
          check_field("error", SYM_W'(seen_res.error), SYM_W'(res_if.error));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // waits drawn per item, with runs of back to back traffic now and then
  function automatic int draw_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 18);
  endfunction

  task automatic send_request(input request_t rq, input bit typed, input bit typed_err);
    int gap;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.operation   = rq.operation;
    req_if.node_slot   = rq.node_slot;
    req_if.child_zero  = rq.child_zero;
    req_if.child_one   = rq.child_one;
    req_if.root_node   = rq.root_node;
    req_if.total_bytes = rq.total_bytes;
    req_if.code_word   = rq.code_word;
    hold_typed         = typed;
    hold_err           = typed_err;
    req_if.valid       = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  // every request sent through here counts toward the random total
  task automatic send_counted(input request_t rq);
    random_items++;
    send_request(rq, 1'b0, 1'b0);
  endtask

  function automatic request_t random_request();
    request_t rq;
    rq.operation   = 2'($urandom_range(0, 3));
    rq.node_slot   = SLOT_W'($urandom());
    rq.child_zero  = NODE_W'($urandom());
    rq.child_one   = NODE_W'($urandom());
    rq.root_node   = NODE_W'($urandom());
    rq.total_bytes = TOTAL_W'($urandom());
    rq.code_word   = $urandom();
    return rq;
  endfunction

  function automatic logic [NODE_W-1:0] pick_child(logic [SLOT_W-1:0] slot);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return NODE_W'($urandom_range(0, 255));
    if (r < 8) return {1'b1, used_slots[$urandom_range(0, used_slots.size() - 1)]};
    return {1'b1, slot};
  endfunction

  function automatic logic [TOTAL_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return TOTAL_W'($urandom_range(1, 40));
    if (r < 19) return TOTAL_W'($urandom_range(1, 24'hFF_FFFF));
    return 24'hFF_FFFF;
  endfunction

  function automatic logic [NODE_W-1:0] pick_root();
    if ($urandom_range(0, 1) == 0) return {1'b1, used_slots[$]};
    return {1'b1, used_slots[$urandom_range(0, used_slots.size() - 1)]};
  endfunction

  task automatic send_node_write();
    request_t rq;
    rq            = random_request();
    rq.operation  = OP_NODE;
    rq.node_slot  = SLOT_W'($urandom_range(0, 255));
    rq.child_zero = pick_child(rq.node_slot);
    rq.child_one  = pick_child(rq.node_slot);
    if (!slot_used[rq.node_slot]) begin
      slot_used[rq.node_slot] = 1'b1;
      used_slots.push_back(rq.node_slot);
    end
    send_counted(rq);
  endtask

  // up to three node writes, a start on a written node, then code words with a node write now and then
  task automatic send_stream();
    request_t rq;
    repeat ($urandom_range(0, 3)) send_node_write();
    rq             = random_request();
    rq.operation   = OP_START;
    rq.root_node   = pick_root();
    rq.total_bytes = pick_count();
    send_counted(rq);
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 7) == 0) send_node_write();
      rq           = random_request();
      rq.operation = OP_CODE;
      send_counted(rq);
    end
  endtask

  task automatic send_noise();
    request_t rq;
    rq = random_request();
    case ($urandom_range(0, 4))
      0: rq.operation = OP_SPARE;
      1: rq.operation = OP_CODE;
      2: begin
        rq.operation   = OP_START;
        rq.root_node   = NODE_W'($urandom_range(0, 255));
        rq.total_bytes = ($urandom_range(0, 3) == 0) ? '0 : pick_count();
      end
      3: begin
        rq.operation   = OP_START;
        rq.root_node   = pick_root();
        rq.total_bytes = '0;
      end
      default: begin
        send_node_write();
        return;
      end
    endcase
    send_counted(rq);
  endtask

  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = draw_gap(sink_burst);
      if (stall > 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready = 1'b1;
      do @(posedge clk); while (!res_if.valid);
      @(negedge clk);
    end
  end

  initial begin : request_source
    int drain;
    req_if.valid       = 1'b0;
    req_if.operation   = OP_NODE;
    req_if.node_slot   = '0;
    req_if.child_zero  = '0;
    req_if.child_one   = '0;
    req_if.root_node   = '0;
    req_if.total_bytes = '0;
    req_if.code_word   = '0;
    hold_typed         = 1'b0;
    hold_err           = 1'b0;
    walk_root          = '0;
    walk_node          = '0;
    bytes_to_go        = '0;
    stream_on          = 1'b0;
    mismatches         = 0;
    cycles             = 0;
    src_burst          = 0;
    sink_burst         = 0;
    random_items       = 0;
    rst_n              = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (directed_rows[i].rq.operation == OP_NODE &&
          !slot_used[directed_rows[i].rq.node_slot]) begin
        slot_used[directed_rows[i].rq.node_slot] = 1'b1;
        used_slots.push_back(directed_rows[i].rq.node_slot);
      end
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].typed_err);
    end

    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) send_stream();
      else send_noise();
    end
    req_if.valid = 1'b0;

    drain = 0;
    while (pending_bytes.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $error("%0d expected results never arrived", pending_bytes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/htd_pkg.sv
hdl/htd_if.sv
hdl/htd_ram.sv
hdl/htd_walker.sv
hdl/huffman_tree_decoder_core.sv
test/tb.sv
